// ===== rtl/opfd_pkg.sv =====
// Shared types and constants for the pulse frame decoder.
package opfd_pkg;

    localparam int unsigned LEN_W     = 16;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned BITS_W    = 20;
    localparam int unsigned ADDR_W    = 12;
    localparam int unsigned BUTTON_W  = 2;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [IDX_W-1:0] PULSE_COUNT    = 6'd42;
    localparam logic [IDX_W-1:0] IDX_MAX        = 6'd63;
    localparam logic [IDX_W-1:0] POS_START      = 6'd1;
    localparam logic [IDX_W-1:0] POS_LAST_PAIR  = 6'd41;
    localparam logic [4:0]       PARITY_LO_BIT  = 5'd12;
    localparam int unsigned      FIXED_BIT      = 2;

    localparam logic [LEN_W-1:0] SHORT_MIN_RST  = 16'd450;
    localparam logic [LEN_W-1:0] MID_SPLIT_RST  = 16'd900;
    localparam logic [LEN_W-1:0] LONG_MAX_RST   = 16'd1400;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_SPLIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_BRIGHT_ADD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GROUP_ADD  = 3'd4;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_LENGTH     = 4'd1,
        ST_START_LONG = 4'd2,
        ST_TOO_LONG   = 4'd3,
        ST_PAIR_LONG  = 4'd4,
        ST_TOO_SHORT  = 4'd5,
        ST_PAIR_SHORT = 4'd6,
        ST_PARITY     = 4'd7,
        ST_FIXED      = 4'd8
    } t_status;

    typedef struct packed {
        logic [LEN_W-1:0] short_min;
        logic [LEN_W-1:0] mid_split;
        logic [LEN_W-1:0] long_max;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]  pulse_index;
        logic [LEN_W-1:0]  held_pulse;
        logic [BITS_W-1:0] shift_bits;
        logic              parity_acc;
        t_status           first_error;
    } t_capture;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   address;
        logic [BUTTON_W-1:0] button;
        logic [CMD_W-1:0]    command;
        logic [BITS_W-1:0]   frame_bits;
    } t_result;

endpackage

// ===== rtl/opfd_step.sv =====
// Per-pulse capture update and frame result decode.
module opfd_step (
    input  opfd_pkg::t_cfg                i_cfg,
    input  opfd_pkg::t_capture            i_cap,
    input  logic [opfd_pkg::LEN_W-1:0]    i_pulse_len,
    input  logic                          i_first_pulse,
    input  logic                          i_last_pulse,
    output opfd_pkg::t_capture            o_cap,
    output opfd_pkg::t_result             o_result
);

    opfd_pkg::t_capture          base;
    opfd_pkg::t_capture          upd;
    opfd_pkg::t_status           cand;
    opfd_pkg::t_status           status;
    logic [opfd_pkg::IDX_W-1:0]  pos;
    logic [4:0]                  bitnum;
    logic                        is_long;
    logic                        held_long;
    logic [5:0]                  low6;
    logic [opfd_pkg::CMD_W-1:0]  cmd;

    always_comb begin
        base = i_first_pulse ? '0 : i_cap;
        pos  = (base.pulse_index == opfd_pkg::IDX_MAX) ? opfd_pkg::IDX_MAX
                                                       : base.pulse_index + 6'd1;
        bitnum    = pos[5:1] - 5'd1;
        is_long   = i_pulse_len > i_cfg.mid_split;
        held_long = base.held_pulse > i_cfg.mid_split;
        upd  = base;
        upd.pulse_index = pos;
        cand = opfd_pkg::ST_OK;

        priority if (pos == opfd_pkg::POS_START) begin
            if (is_long) begin
                cand = opfd_pkg::ST_START_LONG;
            end
        end else if (pos <= opfd_pkg::POS_LAST_PAIR && !pos[0]) begin
            upd.held_pulse = i_pulse_len;
            upd.shift_bits = {base.shift_bits[opfd_pkg::BITS_W-2:0], is_long};
            if (is_long) begin
                if (i_pulse_len > i_cfg.long_max) begin
                    cand = opfd_pkg::ST_TOO_LONG;
                end
                if (bitnum >= opfd_pkg::PARITY_LO_BIT) begin
                    upd.parity_acc = ~base.parity_acc;
                end
            end else if (i_pulse_len < i_cfg.short_min) begin
                cand = opfd_pkg::ST_TOO_SHORT;
            end
        end else if (pos <= opfd_pkg::POS_LAST_PAIR) begin
            if (held_long) begin
                if (is_long) begin
                    cand = opfd_pkg::ST_PAIR_LONG;
                end
            end else if (i_pulse_len < i_cfg.mid_split) begin
                cand = opfd_pkg::ST_PAIR_SHORT;
            end
        end else begin
            cand = opfd_pkg::ST_OK;
        end

        if (base.first_error == opfd_pkg::ST_OK) begin
            upd.first_error = cand;
        end

        priority if (upd.pulse_index != opfd_pkg::PULSE_COUNT) begin
            status = opfd_pkg::ST_LENGTH;
        end else if (upd.first_error != opfd_pkg::ST_OK) begin
            status = upd.first_error;
        end else if (upd.parity_acc) begin
            status = opfd_pkg::ST_PARITY;
        end else if (upd.shift_bits[opfd_pkg::FIXED_BIT]) begin
            status = opfd_pkg::ST_FIXED;
        end else begin
            status = opfd_pkg::ST_OK;
        end

        low6 = upd.shift_bits[5:0];
        priority if (low6[3]) begin
            cmd = {2'b00, low6[4]} + opfd_pkg::CMD_BRIGHT_ADD;
        end else if (low6[5]) begin
            cmd = {2'b00, low6[4]} + opfd_pkg::CMD_GROUP_ADD;
        end else begin
            cmd = {2'b00, low6[4]};
        end

        o_result = '0;
        o_result.status = status;
        if (status == opfd_pkg::ST_OK) begin
            o_result.frame_bits = upd.shift_bits;
            o_result.address    = upd.shift_bits[19:8];
            o_result.button     = {upd.shift_bits[6], upd.shift_bits[7]};
            o_result.command    = cmd;
        end

        o_cap = i_last_pulse ? '0 : upd;
    end

endmodule

// ===== rtl/ook_pulse_frame_decoder.sv =====
// Top level of the pulse frame decoder: input register, capture state, result register.
// The last pulse of a frame waits in the input register; its result is then registered in the result register.
// Throughput: one pulse per cycle; the input stage holds only while a finished result
// sits stalled in the result register and the input stage holds a last pulse.
// Reset: clears both stage valids and the capture state, and loads the threshold
// registers with 450, 900 and 1400.
module ook_pulse_frame_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [opfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [opfd_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [opfd_pkg::LEN_W-1:0]       i_pulse_len,
    input  logic                             i_first_pulse,
    input  logic                             i_last_pulse,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [3:0]                       o_status,
    output logic [opfd_pkg::ADDR_W-1:0]      o_address,
    output logic [opfd_pkg::BUTTON_W-1:0]    o_button,
    output logic [opfd_pkg::CMD_W-1:0]       o_command,
    output logic [opfd_pkg::BITS_W-1:0]      o_frame_bits
);

    opfd_pkg::t_cfg              r_cfg;
    opfd_pkg::t_capture          r_cap;
    opfd_pkg::t_capture          n_cap;
    opfd_pkg::t_result           n_result;
    opfd_pkg::t_result           r_result;
    logic                        r_s1_valid;
    logic [opfd_pkg::LEN_W-1:0]  r_s1_len;
    logic                        r_s1_first;
    logic                        r_s1_last;
    logic                        r_out_valid;
    logic                        out_free;
    logic                        s1_adv;
    logic                        s1_fire;
    logic                        in_fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_last || out_free;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_fire    = i_in_valid && !o_in_stall;

    opfd_step u_step (
        .i_cfg         (r_cfg),
        .i_cap         (r_cap),
        .i_pulse_len   (r_s1_len),
        .i_first_pulse (r_s1_first),
        .i_last_pulse  (r_s1_last),
        .o_cap         (n_cap),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_min <= opfd_pkg::SHORT_MIN_RST;
            r_cfg.mid_split <= opfd_pkg::MID_SPLIT_RST;
            r_cfg.long_max  <= opfd_pkg::LONG_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                opfd_pkg::CFG_SHORT_MIN: r_cfg.short_min <= i_cfg_data;
                opfd_pkg::CFG_MID_SPLIT: r_cfg.mid_split <= i_cfg_data;
                opfd_pkg::CFG_LONG_MAX:  r_cfg.long_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_cap <= n_cap;
            end
            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_len   <= i_pulse_len;
            r_s1_first <= i_first_pulse;
            r_s1_last  <= i_last_pulse;
        end
        if (s1_fire && r_s1_last) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_result.status;
    assign o_address    = r_result.address;
    assign o_button     = r_result.button;
    assign o_command    = r_result.command;
    assign o_frame_bits = r_result.frame_bits;

endmodule

// ===== tb/sv/opfd_frame_checker.sv =====
// Frame result checker for the pulse frame decoder: predicts each result and compares it.
module opfd_frame_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [opfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [opfd_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [opfd_pkg::LEN_W-1:0]       i_pulse_len,
    input  logic                             i_first_pulse,
    input  logic                             i_last_pulse,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [3:0]                       i_status,
    input  logic [opfd_pkg::ADDR_W-1:0]      i_address,
    input  logic [opfd_pkg::BUTTON_W-1:0]    i_button,
    input  logic [opfd_pkg::CMD_W-1:0]       i_command,
    input  logic [opfd_pkg::BITS_W-1:0]      i_frame_bits,
    output int                               o_fail_count,
    output int                               o_pending
);
    import opfd_pkg::*;

    logic [LEN_W-1:0]  lim_short;
    logic [LEN_W-1:0]  lim_mid;
    logic [LEN_W-1:0]  lim_long;

    logic [IDX_W-1:0]  cap_count;
    logic [LEN_W-1:0]  pair_lead;
    logic [BITS_W-1:0] bit_acc;
    logic              par_acc;
    t_status           cap_err;

    t_result           pending_frames[$];
    t_result           want;
    int                mismatches = 0;

    task automatic clear_capture();
        cap_count = '0;
        pair_lead = '0;
        bit_acc   = '0;
        par_acc   = 1'b0;
        cap_err   = ST_OK;
    endtask

    task automatic note_fault(input t_status code);
        if (cap_err == ST_OK) begin
            cap_err = code;
        end
    endtask

    task automatic absorb_pulse(input logic [LEN_W-1:0] len, input logic first,
                                input logic last);
        t_result          frame;
        logic [IDX_W-1:0] pair_pos;
        if (first) begin
            clear_capture();
        end
        if (cap_count != IDX_MAX) begin
            cap_count = cap_count + 1'b1;
        end
        pair_pos = cap_count - 6'd2;
        if (cap_count == POS_START) begin
            if (len > lim_mid) begin
                note_fault(ST_START_LONG);
            end
        end else if (cap_count <= POS_LAST_PAIR && !cap_count[0]) begin
            pair_lead = len;
            bit_acc   = {bit_acc[BITS_W-2:0], 1'b0};
            if (len > lim_mid) begin
                if (len > lim_long) begin
                    note_fault(ST_TOO_LONG);
                end
                bit_acc[0] = 1'b1;
                if (pair_pos[IDX_W-1:1] >= PARITY_LO_BIT) begin
                    par_acc = ~par_acc;
                end
            end else if (len < lim_short) begin
                note_fault(ST_TOO_SHORT);
            end
        end else if (cap_count <= POS_LAST_PAIR) begin
            if (pair_lead > lim_mid) begin
                if (len > lim_mid) begin
                    note_fault(ST_PAIR_LONG);
                end
            end else if (len < lim_mid) begin
                note_fault(ST_PAIR_SHORT);
            end
        end
        if (last) begin
            frame = '0;
            if (cap_count != PULSE_COUNT) begin
                frame.status = ST_LENGTH;
            end else if (cap_err != ST_OK) begin
                frame.status = cap_err;
            end else if (par_acc) begin
                frame.status = ST_PARITY;
            end else if (bit_acc[FIXED_BIT]) begin
                frame.status = ST_FIXED;
            end else begin
                frame.status = ST_OK;
            end
            if (frame.status == ST_OK) begin
                frame.frame_bits = bit_acc;
                frame.address    = bit_acc[BITS_W-1:8];
                frame.button     = {bit_acc[6], bit_acc[7]};
                frame.command    = {2'b00, bit_acc[4]};
                if (bit_acc[3]) begin
                    frame.command = frame.command + CMD_BRIGHT_ADD;
                end else if (bit_acc[5]) begin
                    frame.command = frame.command + CMD_GROUP_ADD;
                end
            end
            pending_frames.push_back(frame);
            clear_capture();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_short = SHORT_MIN_RST;
            lim_mid   = MID_SPLIT_RST;
            lim_long  = LONG_MAX_RST;
            clear_capture();
            pending_frames.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SHORT_MIN: lim_short = i_cfg_data;
                    CFG_MID_SPLIT: lim_mid   = i_cfg_data;
                    CFG_LONG_MAX:  lim_long  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_frames.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result: status %0d address %h button %0d",
                                 $time, i_status, i_address, i_button);
                    end
                end else begin
                    want = pending_frames.pop_front();
                    if (i_status !== want.status || i_address !== want.address ||
                        i_button !== want.button || i_command !== want.command ||
                        i_frame_bits !== want.frame_bits) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch: status %0d/%0d address %h/%h",
                                     $time, want.status, i_status, want.address, i_address);
                            $display("    button %0d/%0d command %0d/%0d bits %h/%h",
                                     want.button, i_button, want.command, i_command,
                                     want.frame_bits, i_frame_bits);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_pulse(i_pulse_len, i_first_pulse, i_last_pulse);
            end
        end
        o_pending    <= pending_frames.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/tb_ook_pulse_frame_decoder.sv =====
// Testbench top for the pulse frame decoder: stimulus, idling, thresholds and verdict.
module tb_ook_pulse_frame_decoder;
    import opfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [3:0] {
        FLAW_NONE,
        FLAW_START,
        FLAW_TOO_LONG,
        FLAW_TOO_SHORT,
        FLAW_PAIR,
        FLAW_PARITY,
        FLAW_FIXED,
        FLAW_LENGTH,
        FLAW_NOISE
    } t_flaw;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [LEN_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [LEN_W-1:0]      i_pulse_len;
    logic                  i_first_pulse;
    logic                  i_last_pulse;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [3:0]            o_status;
    logic [ADDR_W-1:0]     o_address;
    logic [BUTTON_W-1:0]   o_button;
    logic [CMD_W-1:0]      o_command;
    logic [BITS_W-1:0]     o_frame_bits;

    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int unsigned           tx_gap_pct = 0;
    int unsigned           rx_busy_pct = 0;
    int unsigned           rx_hold_cycles = 0;
    int unsigned           sent_items = 0;
    int unsigned           sent_results = 0;
    logic [LEN_W-1:0]      thr_short;
    logic [LEN_W-1:0]      thr_mid;
    logic [LEN_W-1:0]      thr_long;

    ook_pulse_frame_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pulse_len  (i_pulse_len),
        .i_first_pulse(i_first_pulse),
        .i_last_pulse (i_last_pulse),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_address    (o_address),
        .o_button     (o_button),
        .o_command    (o_command),
        .o_frame_bits (o_frame_bits)
    );

    opfd_frame_checker u_frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_pulse_len  (i_pulse_len),
        .i_first_pulse(i_first_pulse),
        .i_last_pulse (i_last_pulse),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_address    (o_address),
        .i_button     (o_button),
        .i_command    (o_command),
        .i_frame_bits (o_frame_bits),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ook_pulse_frame_decoder verification failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [LEN_W-1:0] short_len();
        if (thr_short <= thr_mid) begin
            return LEN_W'($urandom_range(int'(thr_mid), int'(thr_short)));
        end
        return thr_mid;
    endfunction

    function automatic logic [LEN_W-1:0] above_mid(input int unsigned ceiling);
        int unsigned lo;
        lo = int'(thr_mid) + 1;
        if (lo > 65535) begin
            return 16'hFFFF;
        end
        return LEN_W'($urandom_range(ceiling > lo ? ceiling : lo, lo));
    endfunction

    function automatic logic [LEN_W-1:0] edge_len();
        case ($urandom_range(8))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return thr_short;
            3: return thr_short - 1'b1;
            4: return thr_mid;
            5: return thr_mid + 1'b1;
            6: return thr_long;
            7: return thr_long + 1'b1;
            default: return LEN_W'($urandom);
        endcase
    endfunction

    task automatic send_pulse(input logic [LEN_W-1:0] len, input logic first,
                              input logic last);
        int unsigned gap;
        gap = pick_gap(tx_gap_pct);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pulse_len   <= len;
        i_first_pulse <= first;
        i_last_pulse  <= last;
        do @(posedge i_clk); while (o_in_stall);
        sent_items = sent_items + 1;
        if (last) begin
            sent_results = sent_results + 1;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_thresholds(input logic [LEN_W-1:0] s, input logic [LEN_W-1:0] m,
                                  input logic [LEN_W-1:0] l);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SHORT_MIN;
        i_cfg_data  <= s;
        @(posedge i_clk);
        i_cfg_index <= CFG_MID_SPLIT;
        i_cfg_data  <= m;
        @(posedge i_clk);
        i_cfg_index <= CFG_LONG_MAX;
        i_cfg_data  <= l;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_short = s;
        thr_mid   = m;
        thr_long  = l;
    endtask

    task automatic send_frame(input t_flaw flaw);
        logic [LEN_W-1:0]  lens [70];
        logic [BITS_W-1:0] bits;
        int unsigned       n;
        int unsigned       a;
        logic              mark;
        n = PULSE_COUNT;
        for (int i = 0; i < 70; i++) begin
            lens[i] = LEN_W'($urandom);
        end
        bits = BITS_W'($urandom);
        bits[FIXED_BIT] = 1'b0;
        if (^bits[7:0]) begin
            bits[0] = ~bits[0];
        end
        if (flaw == FLAW_PARITY) begin
            bits[1] = ~bits[1];
        end else if (flaw == FLAW_FIXED) begin
            bits[FIXED_BIT] = 1'b1;
            bits[3] = ~bits[3];
        end
        lens[0] = short_len();
        for (int k = 0; k < BITS_W; k++) begin
            a = 1 + 2 * k;
            if (bits[BITS_W-1-k]) begin
                lens[a]     = above_mid(thr_long);
                lens[a + 1] = LEN_W'($urandom_range(int'(thr_mid), 0));
            end else begin
                lens[a]     = short_len();
                lens[a + 1] = LEN_W'($urandom_range(thr_long > thr_mid ? int'(thr_long)
                                                                       : int'(thr_mid),
                                                     int'(thr_mid)));
            end
        end
        a = 1 + 2 * $urandom_range(BITS_W - 1);
        case (flaw)
            FLAW_START: lens[0] = above_mid(65535);
            FLAW_TOO_LONG: begin
                if (thr_long != 16'hFFFF) begin
                    lens[a] = LEN_W'($urandom_range(65535, int'(thr_long) + 1));
                end
            end
            FLAW_TOO_SHORT: begin
                if (thr_short != 0) begin
                    lens[a] = LEN_W'($urandom_range(int'(thr_short) - 1, 0));
                end
            end
            FLAW_PAIR: begin
                if (lens[a] > thr_mid) begin
                    lens[a + 1] = above_mid(65535);
                end else if (thr_mid != 0) begin
                    lens[a + 1] = LEN_W'($urandom_range(int'(thr_mid) - 1, 0));
                end
            end
            FLAW_LENGTH: begin
                n = ($urandom_range(1) != 0) ? $urandom_range(41, 1) : $urandom_range(70, 43);
            end
            FLAW_NOISE: lens[$urandom_range(PULSE_COUNT - 1)] = edge_len();
            default: ;
        endcase
        mark = ($urandom_range(99) < 85);
        for (int unsigned i = 0; i < n; i++) begin
            send_pulse(lens[i], (i == 0) && mark, i == n - 1);
        end
    endtask

    task automatic send_fragment();
        int unsigned      n;
        logic [LEN_W-1:0] len;
        n = $urandom_range(8, 1);
        for (int unsigned i = 0; i < n; i++) begin
            len = ($urandom_range(1) != 0) ? edge_len() : LEN_W'($urandom);
            send_pulse(len, (i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(19) == 0),
                       (i == n - 1) && ($urandom_range(99) < 85));
        end
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] s, input logic [LEN_W-1:0] m,
                             input logic [LEN_W-1:0] l, input int unsigned gap_pct,
                             input int unsigned busy_pct);
        int unsigned item_base;
        int unsigned result_base;
        t_flaw       flaw;
        tx_gap_pct  = gap_pct;
        rx_busy_pct = busy_pct;
        set_thresholds(s, m, l);
        item_base   = sent_items;
        result_base = sent_results;
        while (sent_items - item_base < 60 || sent_results - result_base < 6) begin
            if ($urandom_range(99) < 35) begin
                flaw = ($urandom_range(3) == 0) ? FLAW_NONE
                                                : t_flaw'($urandom_range(int'(FLAW_NOISE)));
                send_frame(flaw);
            end else begin
                send_fragment();
            end
        end
        wait_drained();
    endtask

    initial begin
        int unsigned hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_out_stall <= 1'b1;
            end else begin
                hold = pick_gap(rx_busy_pct);
                i_out_stall <= (hold != 0);
                if (hold == 0) begin
                    hold = 1;
                end
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    initial begin
        int unsigned rnd_short;
        int unsigned rnd_mid;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_SHORT_MIN;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_pulse_len   <= '0;
        i_first_pulse <= 1'b0;
        i_last_pulse  <= 1'b0;
        thr_short = SHORT_MIN_RST;
        thr_mid   = MID_SPLIT_RST;
        thr_long  = LONG_MAX_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pulse(16'hFFFF, 1'b0, 1'b0);
        send_pulse(16'h0000, 1'b0, 1'b1);
        send_pulse(16'd450, 1'b1, 1'b1);
        send_pulse(16'd900, 1'b1, 1'b0);
        send_pulse(16'd901, 1'b0, 1'b0);
        send_pulse(16'd0, 1'b1, 1'b0);
        send_pulse(16'hFFFF, 1'b0, 1'b1);
        send_pulse(16'd1400, 1'b0, 1'b1);
        wait_drained();

        // hold the result side while one-pulse captures pile up
        @(negedge i_clk);
        rx_hold_cycles = 300;
        @(posedge i_clk);
        repeat (10) send_pulse(LEN_W'($urandom), 1'b1, 1'b1);
        wait_drained();

        run_phase(16'd450, 16'd900, 16'd1400, 0, 0);
        run_phase(16'd0, 16'd0, 16'd0, 30, 30);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 20, 40);
        run_phase(16'd0, 16'd32768, 16'hFFFF, 40, 20);
        run_phase(16'd1000, 16'd500, 16'd200, 30, 30);
        rnd_short = $urandom_range(600, 100);
        rnd_mid   = rnd_short + $urandom_range(800, 100);
        run_phase(LEN_W'(rnd_short), LEN_W'(rnd_mid),
                  LEN_W'(rnd_mid + $urandom_range(1500, 100)), 25, 25);

        if (fail_count == 0) begin
            $display("ook_pulse_frame_decoder verification clean");
        end else begin
            $display("ook_pulse_frame_decoder verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/opfd_pkg.sv
rtl/opfd_step.sv
rtl/ook_pulse_frame_decoder.sv
tb/sv/opfd_frame_checker.sv
tb/sv/tb_ook_pulse_frame_decoder.sv
